// ----- src/bfab_pkg.sv -----
// Shared types and codes for the linked-slot message queue.
`default_nettype none
package bfab_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH_TAIL = 3'd0,
		ACT_PUSH_HEAD = 3'd1,
		ACT_POP       = 3'd2,
		ACT_ACK       = 3'd3,
		ACT_REWIND    = 3'd4,
		ACT_LOAD      = 3'd5
	} action_t;

	localparam logic [3:0] ST_STORED     = 4'd0;
	localparam logic [3:0] ST_DROPPED    = 4'd1;
	localparam logic [3:0] ST_POPPED     = 4'd2;
	localparam logic [3:0] ST_EMPTY      = 4'd3;
	localparam logic [3:0] ST_THROTTLED  = 4'd4;
	localparam logic [3:0] ST_ACKED      = 4'd5;
	localparam logic [3:0] ST_NONE_ACKED = 4'd6;
	localparam logic [3:0] ST_DONE       = 4'd7;
	localparam logic [3:0] ST_NO_SLOT    = 4'd8;

	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_THROTTLE = 1'b1;

	localparam logic [10:0] CAPACITY_RESET = 11'd1024;

	typedef enum logic [2:0] {
		MODE_NONE    = 3'd0,
		MODE_ALLOC_T = 3'd1,
		MODE_ALLOC_H = 3'd2,
		MODE_TAKE    = 3'd3,
		MODE_ACK     = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_MEM  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic latch;
		logic eval;
		logic mem;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_mem;
		logic ack_more;
	} stat_t;

endpackage
`default_nettype wire

// ----- src/bounded_fifo_with_ack_backlog.sv -----
// Top level of the linked-slot message queue with output, wait and backlog lists.
// Each word passes through evaluate, a memory phase when it touches a slot, and emit; the result
// strobe is registered after emit, and an ack repeats memory and emit for each further result.
// A new input word is taken only once the block is idle again; the single registered read port
// of the slot memories sets the phases.
// Reset: arst_n clears pointers and counts at once, with no memory clearing pass; the receiver
// cannot stall results.
`default_nettype none
module bounded_fifo_with_ack_backlog #(
	parameter int SLOT_COUNT = 1024,
	parameter int MAX_ACK    = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  action,
	input  wire  [31:0] handle,
	input  wire         ack_req,
	input  wire         to_backlog,
	input  wire         skip_throttle,
	input  wire  [6:0]  ack_count,
	input  wire  [15:0] token_amount,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [10:0] cfg_data,
	output logic        strobe,
	output logic [3:0]  status,
	output logic [31:0] out_handle,
	output logic        out_ack_req,
	output logic        last,
	output logic [10:0] queue_length,
	output logic [10:0] backlog_length
);

	bfab_pkg::cmd_t  cmd;
	bfab_pkg::stat_t stat;

	// Configuration words are taken only while no word is being worked, so a
	// setting never changes in the middle of a word.
	assign cfg_ready = !busy;

	// The controller walks each word through evaluate, memory (when a slot is touched) and emit phases;
	// an ack repeats the memory and emit phases once per released entry.
	bfab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath holds the slot memories, the list pointers and the result register.
	bfab_dpath #(
		.SLOT_COUNT (SLOT_COUNT),
		.MAX_ACK    (MAX_ACK)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.handle          (handle),
		.ack_req         (ack_req),
		.to_backlog      (to_backlog),
		.skip_throttle   (skip_throttle),
		.ack_count       (ack_count),
		.token_amount    (token_amount),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.status          (status),
		.out_handle      (out_handle),
		.out_ack_req     (out_ack_req),
		.last            (last),
		.queue_length    (queue_length),
		.backlog_length  (backlog_length)
	);

endmodule
`default_nettype wire

// ----- src/bfab_ctrl.sv -----
// Sequencing state machine for the linked-slot message queue.
`default_nettype none
module bfab_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  bfab_pkg::stat_t   stat,
	output logic              busy,
	output bfab_pkg::cmd_t    cmd
);

	bfab_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfab_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfab_pkg::S_IDLE: begin
				if (start) state_d = bfab_pkg::S_EVAL;
			end
			bfab_pkg::S_EVAL: begin
				state_d = stat.need_mem ? bfab_pkg::S_MEM : bfab_pkg::S_EMIT;
			end
			bfab_pkg::S_MEM: begin
				state_d = bfab_pkg::S_EMIT;
			end
			bfab_pkg::S_EMIT: begin
				state_d = stat.ack_more ? bfab_pkg::S_MEM : bfab_pkg::S_IDLE;
			end
			default: begin
				state_d = bfab_pkg::S_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != bfab_pkg::S_IDLE);
	assign cmd.latch = (state_q == bfab_pkg::S_IDLE) && start;
	assign cmd.eval  = (state_q == bfab_pkg::S_EVAL);
	assign cmd.mem   = (state_q == bfab_pkg::S_MEM);
	assign cmd.emit  = (state_q == bfab_pkg::S_EMIT);

endmodule
`default_nettype wire

// ----- src/bfab_dpath.sv -----
// Slot memories, list pointers, registers and result register of the queue.
`default_nettype none
module bfab_dpath #(
	parameter int SLOT_COUNT = 1024,
	parameter int MAX_ACK    = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  bfab_pkg::cmd_t    cmd,
	output bfab_pkg::stat_t   stat,
	input  wire  [2:0]        action,
	input  wire  [31:0]       handle,
	input  wire               ack_req,
	input  wire               to_backlog,
	input  wire               skip_throttle,
	input  wire  [6:0]        ack_count,
	input  wire  [15:0]       token_amount,
	input  wire               cfg_we,
	input  wire               cfg_index,
	input  wire  [10:0]       cfg_data,
	output logic              strobe,
	output logic [3:0]        status,
	output logic [31:0]       out_handle,
	output logic              out_ack_req,
	output logic              last,
	output logic [10:0]       queue_length,
	output logic [10:0]       backlog_length
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int LW = $clog2(SLOT_COUNT + 1);
	localparam int QW = LW + 1;
	localparam int CW = QW + 11;
	localparam int NW = LW + 7;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

	logic [31:0]   mem_h [SLOT_COUNT];
	logic          mem_a [SLOT_COUNT];
	logic [SW-1:0] mem_l [SLOT_COUNT];
	logic [31:0]   rd_h_q;
	logic          rd_a_q;
	logic [SW-1:0] rd_l_q;

	logic [10:0]   cap_q;
	logic          thr_q;
	logic [SW-1:0] fh_q;
	logic [LW-1:0] fc_q;
	logic [SW:0]   hw_q;
	logic [SW-1:0] oh_q, ot_q, wh_q, wt_q, bh_q, bt_q;
	logic [LW-1:0] ol_q, wl_q, bl_q;
	logic [15:0]   tok_q;

	bfab_pkg::action_t act_q;
	logic [31:0]   hdl_q;
	logic          ackf_q, tob_q, ign_q;
	logic [6:0]    acnt_q;
	logic [15:0]   amt_q;

	bfab_pkg::mode_t mode_q, mode_d;
	logic [6:0]    cnt_q;
	logic [3:0]    res_st_q, res_st_d;
	logic [31:0]   res_h_q, res_h_d;
	logic          res_a_q, res_a_d;

	logic [QW-1:0] qsum;
	logic          full, nofree, throttled;
	logic [6:0]    lim, ack_n;
	logic [SW-1:0] rd_addr;
	logic          fresh;
	logic [SW-1:0] fh_next;
	logic          l_we;
	logic [SW-1:0] l_addr, l_data;
	logic          h_we;

	assign qsum      = QW'(ol_q) + QW'(wl_q);
	assign full      = CW'(qsum) >= CW'(cap_q);
	assign nofree    = (fc_q == '0);
	assign throttled = !ign_q && thr_q && (tok_q == '0);
	assign lim       = (acnt_q > 7'(MAX_ACK)) ? 7'(MAX_ACK) : acnt_q;
	assign ack_n     = (NW'(lim) > NW'(bl_q)) ? 7'(bl_q) : lim;

	// Slots at or above the high-water mark have never left the free list.
	assign fresh   = ({1'b0, fh_q} == hw_q);
	assign fh_next = fresh ? ((fh_q == LAST_SLOT) ? '0 : fh_q + 1'b1) : rd_l_q;

	// Outcome of the latched item against the current list state.
	always_comb begin
		mode_d   = bfab_pkg::MODE_NONE;
		res_st_d = bfab_pkg::ST_DONE;
		res_h_d  = '0;
		res_a_d  = 1'b0;
		unique case (act_q)
			bfab_pkg::ACT_PUSH_TAIL: begin
				if (full) begin
					res_st_d = bfab_pkg::ST_DROPPED;
					res_h_d  = hdl_q;
					res_a_d  = ackf_q;
				end else if (nofree) begin
					res_st_d = bfab_pkg::ST_NO_SLOT;
					res_h_d  = hdl_q;
					res_a_d  = ackf_q;
				end else begin
					res_st_d = bfab_pkg::ST_STORED;
					mode_d   = bfab_pkg::MODE_ALLOC_T;
				end
			end
			bfab_pkg::ACT_PUSH_HEAD: begin
				if (nofree) begin
					res_st_d = bfab_pkg::ST_NO_SLOT;
					res_h_d  = hdl_q;
					res_a_d  = ackf_q;
				end else begin
					res_st_d = bfab_pkg::ST_STORED;
					mode_d   = bfab_pkg::MODE_ALLOC_H;
				end
			end
			bfab_pkg::ACT_POP: begin
				if (throttled) begin
					res_st_d = bfab_pkg::ST_THROTTLED;
				end else if (ol_q == '0 && wl_q == '0) begin
					res_st_d = bfab_pkg::ST_EMPTY;
				end else begin
					res_st_d = bfab_pkg::ST_POPPED;
					mode_d   = bfab_pkg::MODE_TAKE;
				end
			end
			bfab_pkg::ACT_ACK: begin
				if (ack_n == '0) begin
					res_st_d = bfab_pkg::ST_NONE_ACKED;
				end else begin
					res_st_d = bfab_pkg::ST_ACKED;
					mode_d   = bfab_pkg::MODE_ACK;
				end
			end
			default: begin
				res_st_d = bfab_pkg::ST_DONE;
			end
		endcase
	end

	assign stat.need_mem = (mode_d != bfab_pkg::MODE_NONE);
	assign stat.ack_more = (mode_q == bfab_pkg::MODE_ACK) && (cnt_q != '0);

	// Read address: the slot that the next memory phase works on.
	always_comb begin
		rd_addr = bh_q;
		if (cmd.eval) begin
			priority case (act_q)
				bfab_pkg::ACT_PUSH_TAIL, bfab_pkg::ACT_PUSH_HEAD: rd_addr = fh_q;
				bfab_pkg::ACT_POP: rd_addr = (ol_q == '0) ? wh_q : oh_q;
				default: rd_addr = bh_q;
			endcase
		end
	end

	// Link write port, one write per cycle.
	always_comb begin
		l_we   = 1'b0;
		l_addr = fh_q;
		l_data = fh_q;
		h_we   = 1'b0;
		if (cmd.eval && act_q == bfab_pkg::ACT_REWIND && bl_q != '0 && ol_q != '0) begin
			l_we   = 1'b1;
			l_addr = ot_q;
			l_data = bh_q;
		end else if (cmd.mem) begin
			unique case (mode_q)
				bfab_pkg::MODE_ALLOC_T: begin
					h_we   = 1'b1;
					l_we   = (wl_q != '0);
					l_addr = wt_q;
					l_data = fh_q;
				end
				bfab_pkg::MODE_ALLOC_H: begin
					h_we   = 1'b1;
					l_we   = 1'b1;
					l_addr = fh_q;
					l_data = oh_q;
				end
				bfab_pkg::MODE_TAKE: begin
					if (tob_q) begin
						l_we   = (bl_q != '0);
						l_addr = bt_q;
						l_data = oh_q;
					end else begin
						l_we   = 1'b1;
						l_addr = oh_q;
						l_data = fh_q;
					end
				end
				bfab_pkg::MODE_ACK: begin
					l_we   = 1'b1;
					l_addr = bh_q;
					l_data = fh_q;
				end
				default: begin
					l_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) mem_l[l_addr] <= l_data;
		if (h_we) begin
			mem_h[fh_q] <= hdl_q;
			mem_a[fh_q] <= ackf_q;
		end
		rd_h_q <= mem_h[rd_addr];
		rd_a_q <= mem_a[rd_addr];
		rd_l_q <= mem_l[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q  <= bfab_pkg::action_t'(action);
			hdl_q  <= handle;
			ackf_q <= ack_req;
			tob_q  <= to_backlog;
			ign_q  <= skip_throttle;
			acnt_q <= ack_count;
			amt_q  <= token_amount;
		end
		if (cmd.eval) begin
			res_st_q <= res_st_d;
			res_h_q  <= res_h_d;
			res_a_q  <= res_a_d;
		end else if (cmd.mem && (mode_q == bfab_pkg::MODE_TAKE || mode_q == bfab_pkg::MODE_ACK))
		begin
			res_h_q <= rd_h_q;
			res_a_q <= rd_a_q;
		end
		if (cmd.emit) begin
			status         <= res_st_q;
			out_handle     <= res_h_q;
			out_ack_req    <= res_a_q;
			last           <= !stat.ack_more;
			queue_length   <= 11'(qsum);
			backlog_length <= 11'(bl_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= bfab_pkg::CAPACITY_RESET;
			thr_q  <= 1'b0;
			fh_q   <= '0;
			fc_q   <= LW'(SLOT_COUNT);
			hw_q   <= '0;
			oh_q   <= '0;
			ot_q   <= '0;
			ol_q   <= '0;
			wh_q   <= '0;
			wt_q   <= '0;
			wl_q   <= '0;
			bh_q   <= '0;
			bt_q   <= '0;
			bl_q   <= '0;
			tok_q  <= '0;
			mode_q <= bfab_pkg::MODE_NONE;
			cnt_q  <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
			if (cfg_we) begin
				unique case (cfg_index)
					bfab_pkg::CFG_CAPACITY: cap_q <= cfg_data;
					bfab_pkg::CFG_THROTTLE: thr_q <= cfg_data[0];
					default: cap_q <= cap_q;
				endcase
			end
			if (cmd.eval) begin
				mode_q <= mode_d;
				unique case (act_q)
					bfab_pkg::ACT_POP: begin
						// An empty output list takes over the whole wait list.
						if (!throttled && ol_q == '0 && wl_q != '0) begin
							oh_q <= wh_q;
							ot_q <= wt_q;
							ol_q <= wl_q;
							wh_q <= '0;
							wt_q <= '0;
							wl_q <= '0;
						end
					end
					bfab_pkg::ACT_ACK: begin
						cnt_q <= ack_n;
						bl_q  <= bl_q - LW'(ack_n);
					end
					bfab_pkg::ACT_REWIND: begin
						if (bl_q != '0) begin
							if (ol_q == '0) oh_q <= bh_q;
							ot_q <= bt_q;
							ol_q <= ol_q + bl_q;
							bh_q <= '0;
							bt_q <= '0;
							bl_q <= '0;
						end
					end
					bfab_pkg::ACT_LOAD: begin
						tok_q <= amt_q;
					end
					default: begin
						tok_q <= tok_q;
					end
				endcase
			end
			if (cmd.mem) begin
				unique case (mode_q)
					bfab_pkg::MODE_ALLOC_T: begin
						if (wl_q == '0) wh_q <= fh_q;
						wt_q <= fh_q;
						wl_q <= wl_q + 1'b1;
						fh_q <= fh_next;
						fc_q <= fc_q - 1'b1;
						if (fresh) hw_q <= hw_q + 1'b1;
					end
					bfab_pkg::MODE_ALLOC_H: begin
						if (ol_q == '0) ot_q <= fh_q;
						oh_q <= fh_q;
						ol_q <= ol_q + 1'b1;
						fh_q <= fh_next;
						fc_q <= fc_q - 1'b1;
						if (fresh) hw_q <= hw_q + 1'b1;
					end
					bfab_pkg::MODE_TAKE: begin
						oh_q <= rd_l_q;
						ol_q <= ol_q - 1'b1;
						if (tob_q) begin
							if (bl_q == '0) bh_q <= oh_q;
							bt_q <= oh_q;
							bl_q <= bl_q + 1'b1;
						end else begin
							fh_q <= oh_q;
							fc_q <= fc_q + 1'b1;
						end
						if (!ign_q && tok_q != '0) tok_q <= tok_q - 1'b1;
					end
					bfab_pkg::MODE_ACK: begin
						bh_q  <= rd_l_q;
						fh_q  <= bh_q;
						fc_q  <= fc_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
					end
					default: begin
						cnt_q <= cnt_q;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/bfab_checker.sv -----
// Port-level checks for the message queue and the bind that attaches them.
`default_nettype none
module bfab_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        strobe,
	input wire [3:0]  status,
	input wire        last
);

	// An accepted word keeps the block busy in the following cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after start");

	// More results still to come means the block is still working.
	a_busy_while_more: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy) else $error("idle with results pending");

	// Only ack results can be followed by further results of the same word.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != bfab_pkg::ST_ACKED |-> last)
		else $error("non-ack result without last");

	// Results never come in consecutive cycles.
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("back-to-back result strobes");

endmodule

bind bounded_fifo_with_ack_backlog bfab_checker u_bfab_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.status (status),
	.last   (last)
);
`default_nettype wire

// ----- dv/bounded_fifo_with_ack_backlog_tb.sv -----
// Self-checking testbench for the linked-slot message queue with output, wait and backlog lists.
`default_nettype none
module bounded_fifo_with_ack_backlog_tb;

	localparam int SLOTS = 1024;
	localparam int ACK_LIMIT = 64;
	localparam int CYCLE_LIMIT = 1000000;

	// One result word as seen on the result ports.
	typedef struct {
		logic [3:0]  status;
		logic [31:0] handle;
		logic        ack;
		logic        last;
		logic [10:0] qlen;
		logic [10:0] blen;
	} queue_result_t;

	typedef struct {
		int unsigned hd;
		int unsigned tl;
		int unsigned len;
	} slot_list_t;

	// Scoreboard: keeps its own copy of the slot lists and predicts every
	// result word of each accepted command word.
	class queue_scoreboard;
		logic [31:0]   slot_handle[SLOTS];
		bit            slot_ack[SLOTS];
		int unsigned   slot_link[SLOTS];
		int unsigned   free_hd;
		int unsigned   free_cnt;
		slot_list_t    outq;
		slot_list_t    waitq;
		slot_list_t    backq;
		logic [15:0]   tokens;
		logic [10:0]   capacity;
		bit            throttle_on;
		queue_result_t expected_words[$];
		int            errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_handle[i] = '0;
				slot_ack[i] = 1'b0;
				slot_link[i] = (i + 1) % SLOTS;
			end
			free_hd = 0;
			free_cnt = SLOTS;
			outq = '{0, 0, 0};
			waitq = '{0, 0, 0};
			backq = '{0, 0, 0};
			tokens = '0;
			capacity = bfab_pkg::CAPACITY_RESET;
			throttle_on = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [10:0] value);
			if (idx == bfab_pkg::CFG_CAPACITY) begin
				capacity = value;
			end else begin
				throttle_on = value[0];
			end
		endfunction

		function void list_append(inout slot_list_t l, input int unsigned s);
			if (l.len == 0) begin
				l.hd = s;
			end else begin
				slot_link[l.tl] = s;
			end
			l.tl = s;
			l.len++;
		endfunction

		function int unsigned list_take(inout slot_list_t l);
			int unsigned s;
			s = l.hd;
			l.hd = slot_link[s];
			l.len--;
			return s;
		endfunction

		function void list_splice(inout slot_list_t src, inout slot_list_t dst);
			if (src.len == 0) begin
				return;
			end
			if (dst.len == 0) begin
				dst.hd = src.hd;
			end else begin
				slot_link[dst.tl] = src.hd;
			end
			dst.tl = src.tl;
			dst.len += src.len;
			src = '{0, 0, 0};
		endfunction

		function int unsigned slot_take_free(logic [31:0] h, bit a);
			int unsigned s;
			s = free_hd;
			free_hd = slot_link[s];
			free_cnt--;
			slot_handle[s] = h;
			slot_ack[s] = a;
			return s;
		endfunction

		function void slot_free(int unsigned s);
			slot_link[s] = free_hd;
			free_hd = s;
			free_cnt++;
		endfunction

		// Works out the result words of one accepted command word.
		function void note_command(logic [2:0] act, logic [31:0] h, bit a, bit to_back,
				bit ign, logic [6:0] cnt, logic [15:0] amount);
			queue_result_t words[$];
			queue_result_t w;
			int unsigned s;
			int unsigned lim;
			w = '{bfab_pkg::ST_DONE, '0, 1'b0, 1'b0, '0, '0};
			case (act)
				bfab_pkg::ACT_PUSH_TAIL: begin
					if (outq.len + waitq.len >= capacity) begin
						w.status = bfab_pkg::ST_DROPPED; w.handle = h; w.ack = a;
					end else if (free_cnt == 0) begin
						w.status = bfab_pkg::ST_NO_SLOT; w.handle = h; w.ack = a;
					end else begin
						list_append(waitq, slot_take_free(h, a));
						w.status = bfab_pkg::ST_STORED;
					end
					words.push_back(w);
				end
				bfab_pkg::ACT_PUSH_HEAD: begin
					if (free_cnt == 0) begin
						w.status = bfab_pkg::ST_NO_SLOT; w.handle = h; w.ack = a;
					end else begin
						s = slot_take_free(h, a);
						if (outq.len == 0) begin
							outq.tl = s;
						end
						slot_link[s] = outq.hd;
						outq.hd = s;
						outq.len++;
						w.status = bfab_pkg::ST_STORED;
					end
					words.push_back(w);
				end
				bfab_pkg::ACT_POP: begin
					if (!ign && throttle_on && tokens == 0) begin
						w.status = bfab_pkg::ST_THROTTLED;
					end else begin
						if (outq.len == 0) begin
							list_splice(waitq, outq);
						end
						if (outq.len == 0) begin
							w.status = bfab_pkg::ST_EMPTY;
						end else begin
							s = list_take(outq);
							w.status = bfab_pkg::ST_POPPED;
							w.handle = slot_handle[s];
							w.ack = slot_ack[s];
							if (to_back) begin
								list_append(backq, s);
							end else begin
								slot_free(s);
							end
							if (!ign && tokens > 0) begin
								tokens--;
							end
						end
					end
					words.push_back(w);
				end
				bfab_pkg::ACT_ACK: begin
					lim = (cnt > ACK_LIMIT) ? ACK_LIMIT : cnt;
					for (int i = 0; i < lim && backq.len > 0; i++) begin
						s = list_take(backq);
						w.status = bfab_pkg::ST_ACKED;
						w.handle = slot_handle[s];
						w.ack = slot_ack[s];
						slot_free(s);
						words.push_back(w);
					end
					if (words.size() == 0) begin
						w.status = bfab_pkg::ST_NONE_ACKED;
						words.push_back(w);
					end
				end
				bfab_pkg::ACT_REWIND: begin
					list_splice(backq, outq);
					words.push_back(w);
				end
				bfab_pkg::ACT_LOAD: begin
					tokens = amount;
					words.push_back(w);
				end
				default: begin
					words.push_back(w);
				end
			endcase
			foreach (words[k]) begin
				words[k].last = (k == words.size() - 1);
				words[k].qlen = 11'(outq.len + waitq.len);
				words[k].blen = 11'(backq.len);
				expected_words.push_back(words[k]);
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(queue_result_t got);
			queue_result_t exp;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected result word, status %0d", got.status));
				return;
			end
			exp = expected_words.pop_front();
			if (got.status !== exp.status)
				report($sformatf("status %0d, expected %0d", got.status, exp.status));
			if (got.handle !== exp.handle)
				report($sformatf("handle %h, expected %h", got.handle, exp.handle));
			if (got.ack !== exp.ack)
				report($sformatf("ack flag %b, expected %b", got.ack, exp.ack));
			if (got.last !== exp.last)
				report($sformatf("last %b, expected %b", got.last, exp.last));
			if (got.qlen !== exp.qlen)
				report($sformatf("queue length %0d, expected %0d", got.qlen, exp.qlen));
			if (got.blen !== exp.blen)
				report($sformatf("backlog length %0d, expected %0d", got.blen, exp.blen));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = bfab_pkg::ACT_LOAD;
	logic [31:0] handle = '0;
	logic        ack_req = 1'b0;
	logic        to_backlog = 1'b0;
	logic        skip_throttle = 1'b0;
	logic [6:0]  ack_count = '0;
	logic [15:0] token_amount = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = bfab_pkg::CFG_CAPACITY;
	logic [10:0] cfg_data = '0;
	logic        strobe;
	logic [3:0]  status;
	logic [31:0] out_handle;
	logic        out_ack_req;
	logic        last;
	logic [10:0] queue_length;
	logic [10:0] backlog_length;

	queue_scoreboard sb = new();
	int cycles = 0;
	// When set, the sender keeps start high from one word to the next.
	bit back_to_back = 1'b0;

	bounded_fifo_with_ack_backlog uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.handle(handle), .ack_req(ack_req), .to_backlog(to_backlog),
		.skip_throttle(skip_throttle), .ack_count(ack_count),
		.token_amount(token_amount), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe), .status(status),
		.out_handle(out_handle), .out_ack_req(out_ack_req), .last(last),
		.queue_length(queue_length), .backlog_length(backlog_length)
	);

	always #2 clk = ~clk;

	// Monitor. Everything is sampled at the rising edge, before any of this
	// edge's nonblocking updates land, so the values are the ones the block saw.
	// A result is checked before a word accepted at the same edge is noted,
	// which keeps the expectation order right.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && strobe)
			sb.check_result('{status, out_handle, out_ack_req, last,
				queue_length, backlog_length});
		if (arst_n && start && !busy)
			sb.note_command(action, handle, ack_req, to_backlog, skip_throttle,
				ack_count, token_amount);
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Random gap after a word: mostly none or short, now and then long.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (back_to_back || r < 9) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Presents one command word and holds it until the block takes it.
	task send(logic [2:0] act, logic [31:0] h, bit a, bit to_back, bit ign,
			logic [6:0] cnt, logic [15:0] amount);
		int gap;
		gap = pick_gap();
		action <= act;
		handle <= h;
		ack_req <= a;
		to_backlog <= to_back;
		skip_throttle <= ign;
		ack_count <= cnt;
		token_amount <= amount;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drops start and waits until every expected word has come back, then a
	// few more cycles so the block is surely back in its idle state.
	task drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.expected_words.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	// Register writes only ever happen while the block is drained.
	task write_register(logic idx, logic [10:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_register(idx, value);
	endtask

	// Random word with a realistic mix: mostly pushes and pops, acks with
	// small counts, and the occasional unused action code.
	task send_random();
		int r;
		logic [2:0] act;
		logic [6:0] cnt;
		logic [15:0] amount;
		r = $urandom_range(0, 99);
		if (r < 28) act = bfab_pkg::ACT_PUSH_TAIL;
		else if (r < 38) act = bfab_pkg::ACT_PUSH_HEAD;
		else if (r < 68) act = bfab_pkg::ACT_POP;
		else if (r < 82) act = bfab_pkg::ACT_ACK;
		else if (r < 88) act = bfab_pkg::ACT_REWIND;
		else if (r < 96) act = bfab_pkg::ACT_LOAD;
		else act = 3'($urandom_range(6, 7));
		cnt = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
		amount = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
		send(act, $urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 2) != 0,
			$urandom_range(0, 3) == 0, cnt, amount);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: empty queue cases, field extremes and every action code.
		send(bfab_pkg::ACT_POP, '0, 0, 0, 0, 7'd0, '0);
		send(bfab_pkg::ACT_ACK, '0, 0, 0, 0, 7'd5, '0);
		send(bfab_pkg::ACT_REWIND, '0, 0, 0, 0, 7'd0, '0);
		send(3'd6, '1, 1, 1, 1, '1, '1);
		send(3'd7, '0, 0, 0, 0, '0, '0);
		send(bfab_pkg::ACT_PUSH_TAIL, 32'hFFFF_FFFF, 1, 0, 0, '0, '0);
		send(bfab_pkg::ACT_PUSH_HEAD, 32'h0000_0000, 0, 0, 0, '0, '0);
		send(bfab_pkg::ACT_PUSH_TAIL, 32'hA5A5_5A5A, 1, 0, 0, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 1, 1, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 1, 0, '0, '0);
		send(bfab_pkg::ACT_ACK, '0, 0, 0, 0, 7'd0, '0);
		send(bfab_pkg::ACT_REWIND, '0, 0, 0, 0, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 1, 0, '0, '0);
		send(bfab_pkg::ACT_ACK, '0, 0, 0, 0, 7'd127, '0);
		send(bfab_pkg::ACT_LOAD, '0, 0, 0, 0, '0, 16'hFFFF);
		send(bfab_pkg::ACT_LOAD, '0, 0, 0, 0, '0, 16'h0000);
		drain();

		// Throttling on with no tokens, and a capacity of zero.
		write_register(bfab_pkg::CFG_THROTTLE, 11'd1);
		write_register(bfab_pkg::CFG_CAPACITY, 11'd0);
		send(bfab_pkg::ACT_PUSH_TAIL, 32'h1234_5678, 1, 0, 0, '0, '0);
		send(bfab_pkg::ACT_PUSH_HEAD, 32'h8765_4321, 1, 0, 0, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 0, 0, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 0, 1, '0, '0);
		send(bfab_pkg::ACT_LOAD, '0, 0, 0, 0, '0, 16'd1);
		send(bfab_pkg::ACT_PUSH_HEAD, 32'h0F0F_F0F0, 0, 0, 0, '0, '0);
		send(bfab_pkg::ACT_POP, '0, 0, 0, 0, '0, '0);
		drain();

		// Random phases, each under its own register setting. The sender
		// pauses until everything is back at the end of every phase.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_register(bfab_pkg::CFG_CAPACITY, 11'd2047);
				1: write_register(bfab_pkg::CFG_CAPACITY, 11'd1);
				default: write_register(bfab_pkg::CFG_CAPACITY, 11'($urandom_range(0, 10)));
			endcase
			write_register(bfab_pkg::CFG_THROTTLE, 11'($urandom_range(0, 1)));
			back_to_back = (ph == 3);
			repeat (36) send_random();
			drain();
		end

		// Move many entries to the backlog, ack the largest batch, ack the rest with a
		// second ack, then send a rewind while the backlog is empty.
		write_register(bfab_pkg::CFG_CAPACITY, 11'd2047);
		write_register(bfab_pkg::CFG_THROTTLE, 11'd0);
		back_to_back = 1'b1;
		repeat (70)
			send(bfab_pkg::ACT_PUSH_TAIL, $urandom, 1'($urandom_range(0, 1)), 0, 0, '0, '0);
		repeat (68)
			send(bfab_pkg::ACT_POP, '0, 0, 1, 1'($urandom_range(0, 1)), '0, '0);
		back_to_back = 1'b0;
		send(bfab_pkg::ACT_ACK, '0, 0, 0, 0, 7'd127, '0);
		send(bfab_pkg::ACT_ACK, '0, 0, 0, 0, 7'd64, '0);
		send(bfab_pkg::ACT_REWIND, '0, 0, 0, 0, '0, '0);
		drain();

		// Back to the reset capacity for a last random stretch.
		write_register(bfab_pkg::CFG_CAPACITY, 11'd1024);
		write_register(bfab_pkg::CFG_THROTTLE, 11'd1);
		repeat (20) send_random();
		drain();

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
src/bfab_pkg.sv
src/bfab_ctrl.sv
src/bfab_dpath.sv
src/bounded_fifo_with_ack_backlog.sv
src/bfab_checker.sv
dv/bounded_fifo_with_ack_backlog_tb.sv
